/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

/* hdl/aidse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package aidse_pkg;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_POS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL_KEY = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PART    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic rotate;
    logic push;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* hdl/aidse_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module aidse_cell #(
  parameter int DATA_WIDTH = aidse_pkg::DEFAULT_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire aidse_pkg::cell_ctrl_t ctrl,
  input  wire logic [DATA_WIDTH-1:0] s_in,
  input  wire logic [DATA_WIDTH-1:0] d_in,
  output logic      [DATA_WIDTH-1:0] s,
  output logic      [DATA_WIDTH-1:0] d
);

  // entry ring: rotate toward the head, or reload from the build chain
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s <= d;
    end else if (ctrl.rotate) begin
      s <= s_in;
    end
  end

  // build chain: advance one place on each push
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      d <= d_in;
    end
  end

endmodule
`default_nettype wire

/* hdl/aidse_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aidse_seq #(
  parameter int DEPTH      = aidse_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = aidse_pkg::DEFAULT_DATA_WIDTH,
  parameter int PW         = $clog2(DEPTH),
  parameter int LW         = $clog2(DEPTH + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [aidse_pkg::FUNC_W-1:0]    func,
  input  wire logic [DATA_WIDTH-1:0]           key,
  input  wire logic [PW-1:0]                   position,
  input  wire logic [DATA_WIDTH-1:0]           head,
  output aidse_pkg::cell_ctrl_t                ctrl,
  output logic      [DATA_WIDTH-1:0]           push_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [aidse_pkg::STATUS_W-1:0]  status,
  output logic                                 found,
  output logic      [PW-1:0]                   match_index,
  output logic      [LW-1:0]                   match_count,
  output logic      [DATA_WIDTH-1:0]           read_value,
  output logic      [LW-1:0]                   length_now
);

  typedef enum logic [2:0] {S_IDLE, S_PASS1, S_PASS2, S_LOAD, S_DONE} state_t;

  state_t                        state;
  logic [aidse_pkg::FUNC_W-1:0]  func_r;
  logic [DATA_WIDTH-1:0]         key_r;
  logic [PW-1:0]                 pos_r;
  logic [DATA_WIDTH-1:0]         pivot;
  logic [PW-1:0]                 step;
  logic [LW-1:0]                 len;
  logic [aidse_pkg::STATUS_W-1:0] stat_r;
  logic                          found_r;
  logic [PW-1:0]                 midx_r;
  logic [LW-1:0]                 mcnt_r;
  logic [DATA_WIDTH-1:0]         rval_r;

  logic                          accept;
  logic [aidse_pkg::STATUS_W-1:0] err;
  logic                          modify;
  logic                          last;
  logic                          in_len;
  logic                          hit;
  logic                          lt;
  logic                          push_p1;
  logic                          push_p2;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (step == PW'(DEPTH - 1));
  assign in_len   = (LW'(step) < len);
  assign hit      = (head == key_r);
  assign lt       = ($signed(head) < $signed(pivot));

  // check the request against the current length
  always_comb begin
    err = aidse_pkg::ST_OK;
    unique case (func)
      aidse_pkg::FUNC_INSERT: begin
        if (len == LW'(DEPTH)) err = aidse_pkg::ST_FULL;
        else if (LW'(position) > len) err = aidse_pkg::ST_RANGE;
      end
      aidse_pkg::FUNC_DEL_POS, aidse_pkg::FUNC_READ: begin
        if (len == '0) err = aidse_pkg::ST_EMPTY;
        else if (LW'(position) >= len) err = aidse_pkg::ST_RANGE;
      end
      aidse_pkg::FUNC_DEL_KEY, aidse_pkg::FUNC_PART: begin
        if (len == '0) err = aidse_pkg::ST_EMPTY;
      end
      default: err = aidse_pkg::ST_OK;
    endcase
  end

  always_comb begin
    case (func_r)
      aidse_pkg::FUNC_INSERT, aidse_pkg::FUNC_DEL_POS,
      aidse_pkg::FUNC_DEL_KEY, aidse_pkg::FUNC_PART: modify = 1'b1;
      default: modify = 1'b0;
    endcase
  end

  // pick which entries enter the build chain in each pass; the two passes
  // together push exactly DEPTH words
  always_comb begin
    push_p1 = 1'b0;
    push_p2 = 1'b0;
    case (func_r)
      aidse_pkg::FUNC_INSERT: begin
        push_p1 = (step <= pos_r);
        push_p2 = (step >= pos_r) && !last;
      end
      aidse_pkg::FUNC_DEL_POS: begin
        push_p1 = in_len && (step != pos_r);
        push_p2 = !push_p1;
      end
      aidse_pkg::FUNC_DEL_KEY: begin
        push_p1 = in_len && !hit;
        push_p2 = !push_p1;
      end
      aidse_pkg::FUNC_PART: begin
        push_p1 = (step != '0) && in_len && lt;
        push_p2 = !push_p1;
      end
      default: begin
        push_p1 = 1'b0;
        push_p2 = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.rotate = (state == S_PASS1) || (state == S_PASS2);
    ctrl.push   = ((state == S_PASS1) && push_p1) || ((state == S_PASS2) && push_p2);
    ctrl.load   = (state == S_LOAD);
    push_data   = (func_r == aidse_pkg::FUNC_INSERT && state == S_PASS1 && step == pos_r)
                  ? key_r : head;
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_r  <= func;
            key_r   <= key;
            pos_r   <= position;
            pivot   <= head;
            stat_r  <= err;
            found_r <= 1'b0;
            midx_r  <= '0;
            mcnt_r  <= '0;
            rval_r  <= '0;
            step    <= '0;
            if (err != aidse_pkg::ST_OK || func == aidse_pkg::FUNC_UNUSED) begin
              state <= S_DONE;
            end else begin
              state <= S_PASS1;
            end
          end
        end
        S_PASS1: begin
          if (in_len) begin
            if (func_r == aidse_pkg::FUNC_FIND && hit && !found_r) begin
              found_r <= 1'b1;
              midx_r  <= step;
            end
            if ((func_r == aidse_pkg::FUNC_COUNT || func_r == aidse_pkg::FUNC_DEL_KEY) && hit) begin
              mcnt_r <= mcnt_r + LW'(1);
            end
            if (func_r == aidse_pkg::FUNC_READ && step == pos_r) rval_r <= head;
          end
          step <= last ? '0 : step + PW'(1);
          if (last) state <= modify ? S_PASS2 : S_DONE;
        end
        S_PASS2: begin
          step <= last ? '0 : step + PW'(1);
          if (last) state <= S_LOAD;
        end
        S_LOAD: begin
          case (func_r)
            aidse_pkg::FUNC_INSERT:  len <= len + LW'(1);
            aidse_pkg::FUNC_DEL_POS: len <= len - LW'(1);
            aidse_pkg::FUNC_DEL_KEY: len <= len - mcnt_r;
            default:                 len <= len;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= stat_r;
            found       <= found_r;
            match_index <= midx_r;
            match_count <= mcnt_r;
            read_value  <= rval_r;
            length_now  <= len;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_len_max, clk, rst, len > LW'(DEPTH), "length beyond depth")
  `ASSERT_PROP(a_accept_busy, clk, rst, accept |=> state != S_IDLE, "accept did not start work")
  `ASSERT_PROP(a_load_done, clk, rst, state == S_LOAD |=> state == S_DONE, "reload not followed by result")
  `ASSERT_NEVER(a_push_idle, clk, rst, ctrl.push && !ctrl.rotate, "push outside a pass")

endmodule
`default_nettype wire

/* hdl/array_insert_delete_search_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Ordered array engine: a chain of DEPTH cells holds the signed entries.
// s_* carries one request (func, key, position), m_* one result per request.
// Each request is taken only when the engine is idle; one request at a time.
// Work per request, from transfer in to result valid:
//   - errors and the unused code: straight to the result register
//   - find, count, read: one rotation of the entry ring past the
//     head cell, which compares one entry per cycle
//   - insert, delete at position, delete key, partition: two rotations
//     that feed a second cell chain, then a reload of the ring from it
// The result sits in an output register; a stalled receiver does not stop
// the next request from being taken, but a new result waits in the sequencer
// until the previous one is transferred.
// Reset empties the array (length zero); entry contents are not cleared,
// no clearing pass is needed.
module array_insert_delete_search_engine #(
  parameter int DEPTH      = aidse_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = aidse_pkg::DEFAULT_DATA_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // func, key, position (low bit up), zero padded to bytes
  input  wire logic [((aidse_pkg::FUNC_W + DATA_WIDTH + $clog2(DEPTH) + 7) / 8) * 8 - 1:0]
                    s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // status, found, match_index, match_count, read_value, length_now, zero padded
  output logic [((aidse_pkg::STATUS_W + 1 + $clog2(DEPTH) + 2 * $clog2(DEPTH + 1)
                 + DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int FW    = aidse_pkg::FUNC_W;
  localparam int SW    = aidse_pkg::STATUS_W;
  localparam int IN_W  = FW + DATA_WIDTH + PW;
  localparam int OUT_W = SW + 1 + PW + 2 * LW + DATA_WIDTH;
  localparam int IN_B  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_B = ((OUT_W + 7) / 8) * 8;

  aidse_pkg::cell_ctrl_t  ctrl;
  logic [DATA_WIDTH-1:0]  push_data;
  logic [DATA_WIDTH-1:0]  s_q [DEPTH];
  logic [DATA_WIDTH-1:0]  d_q [DEPTH];
  logic [SW-1:0]          status;
  logic                   found;
  logic [PW-1:0]          match_index;
  logic [LW-1:0]          match_count;
  logic [DATA_WIDTH-1:0]  read_value;
  logic [LW-1:0]          length_now;
  logic [IN_B-1:0]        in_word;

  assign in_word = s_tdata;

  aidse_seq #(
    .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .PW(PW), .LW(LW)
  ) u_seq (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .func(in_word[FW-1:0]),
    .key(in_word[FW+DATA_WIDTH-1:FW]),
    .position(in_word[IN_W-1:FW+DATA_WIDTH]),
    .head(s_q[0]),
    .ctrl(ctrl), .push_data(push_data),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .found(found), .match_index(match_index),
    .match_count(match_count), .read_value(read_value), .length_now(length_now)
  );

  // cell chain: ring wraps head to tail, build chain fed at the tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      aidse_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(ctrl), .s_in(s_q[0]), .d_in(push_data),
        .s(s_q[i]), .d(d_q[i])
      );
    end else begin : g_body
      aidse_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(ctrl), .s_in(s_q[i+1]), .d_in(d_q[i+1]),
        .s(s_q[i]), .d(d_q[i])
      );
    end
  end

  // pack the result
  assign m_tdata = OUT_B'({length_now, read_value, match_count, match_index, found, status});

endmodule
`default_nettype wire

/* verif/array_insert_delete_search_engine_tb.sv */
`timescale 1ns / 1ps
module array_insert_delete_search_engine_tb;

  localparam int DEPTH  = 64;
  localparam int DW     = 32;
  localparam int IN_W   = ((aidse_pkg::FUNC_W + DW + 6 + 7) / 8) * 8;
  localparam int OUT_W  = ((aidse_pkg::STATUS_W + 1 + 6 + 2 * 7 + DW + 7) / 8) * 8;

  typedef struct packed {
    logic [6:0]    length_now;
    logic [DW-1:0] read_value;
    logic [6:0]    match_count;
    logic [5:0]    match_index;
    logic          found;
    logic [1:0]    status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // golden copy of the array
  logic signed [DW-1:0] gold_array [DEPTH];
  int unsigned gold_len;
  result_t pending_results [$];
  int mismatches;
  int hold_off_cycles;
  int last_key_pool [$];

  array_insert_delete_search_engine #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // compute the result of one operation and update the golden array
  function automatic result_t apply_op(logic [2:0] op, logic signed [DW-1:0] key,
                                       int unsigned pos);
    result_t r;
    logic signed [DW-1:0] buffer [DEPTH];
    logic signed [DW-1:0] pivot;
    int unsigned j;
    r = '0;
    case (op)
      aidse_pkg::FUNC_INSERT: begin
        if (gold_len >= DEPTH) r.status = aidse_pkg::ST_FULL;
        else if (pos > gold_len) r.status = aidse_pkg::ST_RANGE;
        else begin
          for (int i = gold_len; i > pos; i--) gold_array[i] = gold_array[i-1];
          gold_array[pos] = key;
          gold_len++;
        end
      end
      aidse_pkg::FUNC_FIND: begin
        for (int i = 0; i < gold_len; i++)
          if (!r.found && gold_array[i] == key) begin
            r.found = 1'b1;
            r.match_index = 6'(i);
          end
      end
      aidse_pkg::FUNC_COUNT: begin
        for (int i = 0; i < gold_len; i++)
          if (gold_array[i] == key) r.match_count++;
      end
      aidse_pkg::FUNC_DEL_POS: begin
        if (gold_len == 0) r.status = aidse_pkg::ST_EMPTY;
        else if (pos >= gold_len) r.status = aidse_pkg::ST_RANGE;
        else begin
          for (int i = pos; i + 1 < gold_len; i++) gold_array[i] = gold_array[i+1];
          gold_len--;
        end
      end
      aidse_pkg::FUNC_DEL_KEY: begin
        if (gold_len == 0) r.status = aidse_pkg::ST_EMPTY;
        else begin
          j = 0;
          for (int i = 0; i < gold_len; i++)
            if (gold_array[i] != key) gold_array[j++] = gold_array[i];
            else r.match_count++;
          gold_len = j;
        end
      end
      aidse_pkg::FUNC_PART: begin
        if (gold_len == 0) r.status = aidse_pkg::ST_EMPTY;
        else begin
          pivot = gold_array[0];
          j = 0;
          for (int i = 1; i < gold_len; i++)
            if (gold_array[i] < pivot) buffer[j++] = gold_array[i];
          buffer[j++] = pivot;
          for (int i = 1; i < gold_len; i++)
            if (!(gold_array[i] < pivot)) buffer[j++] = gold_array[i];
          for (int i = 0; i < gold_len; i++) gold_array[i] = buffer[i];
        end
      end
      aidse_pkg::FUNC_READ: begin
        if (gold_len == 0) r.status = aidse_pkg::ST_EMPTY;
        else if (pos >= gold_len) r.status = aidse_pkg::ST_RANGE;
        else r.read_value = gold_array[pos];
      end
      default: ;
    endcase
    r.length_now = 7'(gold_len);
    return r;
  endfunction

  // short random gap, now and then a long one
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // offer one operation and wait for its transfer
  task automatic send_op(logic [2:0] op, logic signed [DW-1:0] key, logic [5:0] pos,
                         bit gaps = 1'b1);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tdata  <= IN_W'({pos, key, op});
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_op(op, key, pos));
    last_key_pool.push_back(key);
    if (last_key_pool.size() > 16) void'(last_key_pool.pop_front());
  endtask

  // drop valid and hold until every expected result has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [DW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3) - 2;
      1: if (last_key_pool.size() != 0)
           return last_key_pool[$urandom_range(0, last_key_pool.size() - 1)];
         else return $urandom;
      default: return $urandom;
    endcase
  endfunction

  // extremes, every operation and the error cases
  task automatic test_directed();
    send_op(aidse_pkg::FUNC_FIND, 5, 0);
    send_op(aidse_pkg::FUNC_COUNT, 5, 0);
    send_op(aidse_pkg::FUNC_DEL_POS, 0, 0);
    send_op(aidse_pkg::FUNC_DEL_KEY, 0, 0);
    send_op(aidse_pkg::FUNC_PART, 0, 0);
    send_op(aidse_pkg::FUNC_READ, 0, 0);
    send_op(aidse_pkg::FUNC_INSERT, 1, 1);
    send_op(aidse_pkg::FUNC_INSERT, 32'sh7fffffff, 0);
    send_op(aidse_pkg::FUNC_INSERT, 32'sh80000000, 1);
    send_op(aidse_pkg::FUNC_INSERT, -1, 0);
    send_op(aidse_pkg::FUNC_INSERT, 0, 3);
    send_op(aidse_pkg::FUNC_INSERT, -1, 2);
    send_op(aidse_pkg::FUNC_FIND, -1, 0);
    send_op(aidse_pkg::FUNC_COUNT, -1, 0);
    send_op(aidse_pkg::FUNC_PART, 0, 0);
    send_op(aidse_pkg::FUNC_READ, 0, 63);
    send_op(aidse_pkg::FUNC_READ, 0, 2);
    send_op(aidse_pkg::FUNC_DEL_POS, 0, 5);
    send_op(aidse_pkg::FUNC_DEL_POS, 0, 1);
    send_op(aidse_pkg::FUNC_DEL_KEY, -1, 0);
    send_op(aidse_pkg::FUNC_UNUSED, -1, 63);
    send_op(aidse_pkg::FUNC_DEL_KEY, 32'sh7fffffff, 0);
    send_op(aidse_pkg::FUNC_DEL_KEY, 0, 0);
    send_op(aidse_pkg::FUNC_READ, 0, 0);
  endtask

  // fill to full, hit the full error, then drain by position
  task automatic test_full_array();
    while (gold_len < DEPTH)
      send_op(aidse_pkg::FUNC_INSERT, pick_key(), 6'($urandom_range(0, gold_len)), 1'b0);
    send_op(aidse_pkg::FUNC_INSERT, 7, 0);
    send_op(aidse_pkg::FUNC_PART, 0, 0);
    send_op(aidse_pkg::FUNC_READ, 0, 63);
    send_op(aidse_pkg::FUNC_FIND, last_key_pool[0], 0);
    send_op(aidse_pkg::FUNC_DEL_POS, 0, 63);
    send_op(aidse_pkg::FUNC_INSERT, 9, 63);
    wait_drained();
    while (gold_len > 0)
      send_op(aidse_pkg::FUNC_DEL_POS, 0, 6'($urandom_range(0, gold_len - 1)), 1'b0);
  endtask

  // receiver stalls long while requests keep coming
  task automatic test_backpressure();
    hold_off_cycles = 600;
    for (int i = 0; i < 12; i++) send_op(aidse_pkg::FUNC_INSERT, pick_key(), 0, 1'b0);
    wait_drained();
  endtask

  // random mix weighted toward valid operations
  task automatic test_random(int n);
    logic [2:0] op;
    logic [5:0] pos;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = aidse_pkg::FUNC_INSERT;
        6, 7: op = aidse_pkg::FUNC_FIND;
        8, 9: op = aidse_pkg::FUNC_COUNT;
        10, 11: op = aidse_pkg::FUNC_DEL_POS;
        12: op = aidse_pkg::FUNC_DEL_KEY;
        13, 14: op = aidse_pkg::FUNC_PART;
        15, 16, 17: op = aidse_pkg::FUNC_READ;
        18: op = aidse_pkg::FUNC_UNUSED;
        default: op = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 7) == 0) pos = 6'($urandom_range(0, 63));
      else if (op == aidse_pkg::FUNC_INSERT) pos = 6'($urandom_range(0, gold_len));
      else pos = (gold_len == 0) ? 6'd0 : 6'($urandom_range(0, gold_len - 1));
      send_op(op, pick_key(), pos);
      if (i == n / 2) wait_drained();
    end
  endtask

  // receiver readiness with random gaps and a forced hold-off
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
        m_tready <= 1'b1;
      end else m_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d f=%0d idx=%0d cnt=%0d val=%h len=%0d",
                      " got st=%0d f=%0d idx=%0d cnt=%0d val=%h len=%0d"},
                     want.status, want.found, want.match_index, want.match_count,
                     want.read_value, want.length_now, got.status, got.found,
                     got.match_index, got.match_count, got.read_value, got.length_now);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("array_insert_delete_search_engine_tb: errors");
    $finish;
  end

  initial begin
    gold_len = 0;
    mismatches = 0;
    hold_off_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_array();
    test_backpressure();
    test_random(300);
    wait_drained();
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("array_insert_delete_search_engine_tb: clean");
    else
      $display("array_insert_delete_search_engine_tb: errors");
    $finish;
  end

endmodule
